// File: design/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants for the cursor sequence buffer.
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int CAPACITY   = 64;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DATA_WIDTH = 32;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_ATTACH  = 3'd3,
        CMD_REMOVE  = 3'd4,
        CMD_QUERY   = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_ITEM = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_FETCH,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status               status;
        logic                  has_current;
        logic [DATA_WIDTH-1:0] value;
        logic [CNT_W-1:0]      count;
    } t_result;

endpackage

// File: design/csb_ram.sv
// ----------------------------------------------------------------------------
// csb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl
// Command sequencer: decodes a command, moves entries through the RAM one
// at a time, places new entries and fetches the current value.
// ----------------------------------------------------------------------------
module csb_ctrl
    import csb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [DATA_WIDTH-1:0] i_entry,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res,
    output logic                  o_mem_we,
    output logic [ADDR_W-1:0]     o_mem_waddr,
    output logic [DATA_WIDTH-1:0] o_mem_wdata,
    output logic                  o_mem_re,
    output logic [ADDR_W-1:0]     o_mem_raddr,
    input  logic [DATA_WIDTH-1:0] i_mem_rdata
);

    t_state                r_state,  n_state;
    logic [CNT_W-1:0]      r_count,  n_count;
    logic [CNT_W-1:0]      r_cursor, n_cursor;
    logic [CNT_W-1:0]      r_idx,    n_idx;
    logic                  r_ins,    n_ins;
    t_status               r_status, n_status;
    logic [DATA_WIDTH-1:0] r_entry,  n_entry;

    logic             present;
    logic             full;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] idx_dn;
    logic [CNT_W-1:0] idx_up;

    assign present = (r_cursor < r_count);
    assign full    = (r_count >= FULL_COUNT);
    assign idx_dn  = r_idx - CNT_W'(1);
    assign idx_up  = r_idx + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ins    <= n_ins;
        r_status <= n_status;
        r_entry  <= n_entry;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_idx       = r_idx;
        n_ins       = r_ins;
        n_status    = r_status;
        n_entry     = r_entry;
        pos         = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[ADDR_W-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_cursor[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_status = ST_OK;
                    n_entry  = i_entry;
                    n_state  = S_FETCH;
                    case (t_cmd'(i_cmd))
                        CMD_START: begin
                            n_cursor = '0;
                        end
                        CMD_ADVANCE: begin
                            if (present) begin
                                n_cursor = r_cursor + CNT_W'(1);
                            end else begin
                                n_status = ST_NO_ITEM;
                            end
                        end
                        CMD_INSERT, CMD_ATTACH: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                if (t_cmd'(i_cmd) == CMD_INSERT) begin
                                    pos = present ? r_cursor : '0;
                                end else begin
                                    pos = present ? r_cursor + CNT_W'(1) : r_count;
                                end
                                n_cursor = pos;
                                n_idx    = r_count;
                                n_ins    = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                                n_state  = (r_count > pos) ? S_SHIFT_RD : S_PLACE;
                            end
                        end
                        CMD_REMOVE: begin
                            if (present) begin
                                // close the gap: entries above the cursor move down
                                n_idx   = r_cursor;
                                n_ins   = 1'b0;
                                n_count = r_count - CNT_W'(1);
                                if (r_cursor + CNT_W'(1) < r_count) begin
                                    n_state = S_SHIFT_RD;
                                end
                            end else begin
                                n_status = ST_NO_ITEM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_ins ? idx_dn[ADDR_W-1:0] : idx_up[ADDR_W-1:0];
                n_state     = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_mem_we = 1'b1;
                if (r_ins) begin
                    n_idx   = idx_dn;
                    n_state = (idx_dn > r_cursor) ? S_SHIFT_RD : S_PLACE;
                end else begin
                    n_idx   = idx_up;
                    n_state = (idx_up < r_count) ? S_SHIFT_RD : S_FETCH;
                end
            end
            S_PLACE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cursor[ADDR_W-1:0];
                o_mem_wdata = r_entry;
                n_state     = S_FETCH;
            end
            S_FETCH: begin
                o_mem_re = present;
                n_state  = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.status      = r_status;
    assign o_res.has_current = present;
    assign o_res.value       = present ? i_mem_rdata : '0;
    assign o_res.count       = r_count;

endmodule

// File: design/cursor_sequence_buffer.sv
// ----------------------------------------------------------------------------
// cursor_sequence_buffer
// Ordered store of up to 64 values with a cursor on the current item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per transaction (start, advance,
//   insert before, attach after, remove, query). Master channel returns
//   exactly one result per command: status, has_current, current value
//   and item count after the command.
//   Values live in a 64 x 32 RAM with a registered read. Insert, attach
//   and remove move entries through that single RAM port pair one entry
//   at a time (read, then write back one slot over).
//   A command moves the sequencer from idle through a read and write-back
//   per moved entry (up to 63, for an insert or remove at the front), a
//   place step for a new entry, then fetch and done; start, advance, query
//   and rejected commands go straight to fetch. The result is presented
//   on the master side the cycle after the sequencer finishes.
//   Reset empties the store and clears the cursor at once; RAM contents
//   are not cleared, since only slots below the count are ever read.
//   A finished result waits in the output register while the next command
//   is taken; if the receiver stalls with that register full, the next
//   result holds in the sequencer and no further command is accepted.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer
    import csb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // [2:0] command, [34:3] entry, rest zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // [1:0] status, [2] has_current,
                                         // [34:3] current_value, [41:35] item_count
);

    t_result               res;
    logic                  res_valid;
    logic                  res_ready;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic    r_out_valid;
    t_result r_out;

    csb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_cmd       (i_s_axis_tdata[CMD_W-1:0]),
        .i_entry     (i_s_axis_tdata[CMD_W +: DATA_WIDTH]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    csb_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: load when empty or when the held transaction drains.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.count, r_out.value, r_out.has_current,
                              r_out.status};

endmodule
